### rtl/rrtt_pkg.sv
`default_nettype none
package rrtt_pkg;
    localparam int MAX_TASKS = 16;
    localparam int ID_BITS = 16;
    localparam int SLOT_BITS = $clog2(MAX_TASKS);
    localparam int CNT_BITS = $clog2(MAX_TASKS + 1);

    typedef logic [1:0] func_t;
    localparam func_t FUNC_CREATE = 2'd0;
    localparam func_t FUNC_KILL   = 2'd1;
    localparam func_t FUNC_NEXT   = 2'd2;
    localparam func_t FUNC_WAIT   = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_FULL       = 3'd1;
    localparam status_t ST_NOT_FOUND  = 3'd2;
    localparam status_t ST_IDLE       = 3'd3;
    localparam status_t ST_NONE_READY = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input transfer, clear scan state
        logic scan_step;  // examine slot at scan index, advance
        logic finish;     // apply the command, form the result
        logic out_take;   // result transferred
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_full;
    } stat_t;
endpackage
`default_nettype wire

### rtl/rrtt_ctrl.sv
`default_nettype none
module rrtt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           out_ready,
    input  wire rrtt_pkg::stat_t stat,
    output rrtt_pkg::cmd_t      cmd
);
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        in_ready = (state_reg == S_IDLE) && !stat.out_full;
        cmd.load = in_valid && in_ready;
        cmd.scan_step = (state_reg == S_SCAN) && !stat.scan_done;
        cmd.finish = (state_reg == S_FINISH);
        cmd.out_take = stat.out_full && out_ready;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (cmd.load) state_next = S_SCAN;
            S_SCAN:   if (stat.scan_done) state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

### rtl/rrtt_datapath.sv
`default_nettype none
module rrtt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rrtt_pkg::cmd_t                cmd,
    output rrtt_pkg::stat_t                    stat,
    input  wire logic [1:0]                    func,
    input  wire logic [rrtt_pkg::ID_BITS-1:0]  task_id,
    input  wire logic [rrtt_pkg::ID_BITS-1:0]  parent_id,
    input  wire logic                          has_parent,
    input  wire logic                          wait_flag,
    output logic [2:0]                         status,
    output logic [15:0]                        result_id,
    output logic [4:0]                         killed_count
);
    localparam int N = rrtt_pkg::MAX_TASKS;
    localparam int SB = rrtt_pkg::SLOT_BITS;
    localparam int CB = rrtt_pkg::CNT_BITS;
    localparam int IB = rrtt_pkg::ID_BITS;

    // Table: slots form a prefix of length count_reg in insertion order.
    logic [IB-1:0] id_reg     [N];
    logic [IB-1:0] par_reg    [N];
    logic          child_reg  [N];
    logic          wait_reg   [N];
    logic [CB-1:0] count_reg;
    logic [IB-1:0] cur_id_reg, ctr_reg;
    logic          cur_known_reg;

    // captured command
    rrtt_pkg::func_t f_reg;
    logic [IB-1:0] tid_reg, pid_reg;
    logic          hp_reg, wf_reg;

    // scan state
    logic [CB-1:0] idx_reg;
    logic          tid_hit_reg, pid_hit_reg, cur_hit_reg;
    logic [SB-1:0] tid_pos_reg, cur_pos_reg;
    logic [N-1:0]  kill_reg;
    logic [CB-1:0] nkill_reg;

    logic          out_full_reg;
    rrtt_pkg::status_t st_reg;
    logic [IB-1:0] rid_reg;
    logic [CB-1:0] kc_reg;

    logic [SB-1:0] si;
    logic          in_tab;
    assign si = idx_reg[SB-1:0];
    assign in_tab = idx_reg < count_reg;

    assign stat.scan_done = (idx_reg == CB'(N));
    assign stat.out_full = out_full_reg;

    // select next: first non-waiting slot after start, wrapping, current last
    logic [SB:0] start;      // start position, N means "before slot 0"
    logic          found;
    logic [SB-1:0] pick;
    always_comb
    begin
        logic [SB:0] p;
        found = 1'b0;
        pick = '0;
        start = (cur_known_reg && cur_hit_reg) ? {1'b0, cur_pos_reg} : (SB+1)'(N);
        for (int k = 0; k < N; k++)
        begin
            p = (SB+1)'(k);
            if (!found && p < (SB+1)'(count_reg) && !wait_reg[k] &&
                (start == (SB+1)'(N) || p > start))
            begin
                found = 1'b1;
                pick = SB'(k);
            end
        end
        for (int k = 0; k < N; k++)
        begin
            p = (SB+1)'(k);
            if (!found && p < (SB+1)'(count_reg) && !wait_reg[k] &&
                start != (SB+1)'(N) && p <= start)
            begin
                found = 1'b1;
                pick = SB'(k);
            end
        end
    end

    // compaction target for each slot: number of survivors before it
    logic [SB-1:0] dest [N];
    always_comb
    begin
        logic [CB-1:0] w;
        w = '0;
        for (int r = 0; r < N; r++)
        begin
            dest[r] = w[SB-1:0];
            if (!kill_reg[r]) w = w + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cur_id_reg <= '0;
            cur_known_reg <= 1'b0;
            ctr_reg <= '0;
            out_full_reg <= 1'b0;
            idx_reg <= CB'(N);
        end
        else
        begin
            if (cmd.out_take) out_full_reg <= 1'b0;
            if (cmd.load)
            begin
                f_reg <= func;
                tid_reg <= task_id;
                pid_reg <= parent_id;
                hp_reg <= has_parent;
                wf_reg <= wait_flag;
                idx_reg <= '0;
                tid_hit_reg <= 1'b0;
                pid_hit_reg <= 1'b0;
                cur_hit_reg <= 1'b0;
                tid_pos_reg <= '0;
                cur_pos_reg <= '0;
                kill_reg <= '0;
                nkill_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                // one slot a cycle: oldest match wins
                if (in_tab)
                begin
                    if (id_reg[si] == tid_reg && !tid_hit_reg)
                    begin
                        tid_hit_reg <= 1'b1;
                        tid_pos_reg <= si;
                    end
                    if (id_reg[si] == pid_reg) pid_hit_reg <= 1'b1;
                    if (id_reg[si] == cur_id_reg && !cur_hit_reg)
                    begin
                        cur_hit_reg <= 1'b1;
                        cur_pos_reg <= si;
                    end
                    if (id_reg[si] == tid_reg ||
                        (child_reg[si] && par_reg[si] == tid_reg && id_reg[si] != '0))
                    begin
                        kill_reg[si] <= 1'b1;
                        nkill_reg <= nkill_reg + 1'b1;
                    end
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_full_reg <= 1'b1;
                st_reg <= rrtt_pkg::ST_OK;
                rid_reg <= '0;
                kc_reg <= '0;
                unique case (f_reg)
                    rrtt_pkg::FUNC_CREATE:
                    begin
                        if (count_reg == CB'(N)) st_reg <= rrtt_pkg::ST_FULL;
                        else if (hp_reg && !pid_hit_reg) st_reg <= rrtt_pkg::ST_NOT_FOUND;
                        else
                        begin
                            id_reg[count_reg[SB-1:0]] <= ctr_reg;
                            par_reg[count_reg[SB-1:0]] <= hp_reg ? pid_reg : '0;
                            child_reg[count_reg[SB-1:0]] <= hp_reg;
                            wait_reg[count_reg[SB-1:0]] <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                cur_id_reg <= ctr_reg;
                                cur_known_reg <= 1'b1;
                            end
                            rid_reg <= ctr_reg;
                            ctr_reg <= ctr_reg + 1'b1;
                        end
                    end
                    rrtt_pkg::FUNC_KILL:
                    begin
                        if (tid_reg == '0) st_reg <= rrtt_pkg::ST_IDLE;
                        else if (!tid_hit_reg) st_reg <= rrtt_pkg::ST_NOT_FOUND;
                        else
                        begin
                            // drop marked slots, move survivors down
                            for (int r = 0; r < N; r++)
                                if (CB'(r) < count_reg && !kill_reg[r])
                                begin
                                    id_reg[dest[r]] <= id_reg[r];
                                    par_reg[dest[r]] <= par_reg[r];
                                    child_reg[dest[r]] <= child_reg[r];
                                    wait_reg[dest[r]] <= wait_reg[r];
                                end
                            count_reg <= count_reg - nkill_reg;
                            kc_reg <= nkill_reg;
                            begin
                                logic first_done;
                                first_done = 1'b0;
                                cur_id_reg <= '0;
                                cur_known_reg <= 1'b0;
                                for (int r = 0; r < N; r++)
                                    if (!first_done && CB'(r) < count_reg && !kill_reg[r])
                                    begin
                                        first_done = 1'b1;
                                        cur_id_reg <= id_reg[r];
                                        cur_known_reg <= 1'b1;
                                    end
                            end
                        end
                    end
                    rrtt_pkg::FUNC_NEXT:
                    begin
                        if (!found) st_reg <= rrtt_pkg::ST_NONE_READY;
                        else
                        begin
                            cur_id_reg <= id_reg[pick];
                            cur_known_reg <= 1'b1;
                            rid_reg <= id_reg[pick];
                        end
                    end
                    rrtt_pkg::FUNC_WAIT:
                    begin
                        if (!tid_hit_reg) st_reg <= rrtt_pkg::ST_NOT_FOUND;
                        else wait_reg[tid_pos_reg] <= wf_reg;
                    end
                    default: st_reg <= rrtt_pkg::ST_OK;
                endcase
            end
        end
    end

    assign status = st_reg;
    assign result_id = rid_reg;
    assign killed_count = 5'(kc_reg);
endmodule
`default_nettype wire

### rtl/round_robin_task_table.sv
`default_nettype none
// Round-robin task table.
// Input channel (in_valid/in_ready) carries one command: func, task_id,
// parent_id, has_parent, wait_flag. Output channel (out_valid/out_ready)
// returns one result per command: status, result_id, killed_count.
// Commands: create a task, kill a task with its direct children, select
// the next ready task in insertion order, or set a task's wait flag.
// From an input transfer, the datapath scans every slot of the table,
// the controller leaves the scan, and an apply cycle forms the result.
// A command is not taken while an earlier one is in the scan or apply
// states, or while its result still waits in the output register.
// The result sits in an output register; a new command is taken only
// once the previous result has been transferred, so a stalled receiver
// holds the block with its state intact.
// Reset empties the table, clears the current task and the id counter;
// no clearing pass is needed.
module round_robin_task_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] task_id,
    input  wire logic [15:0] parent_id,
    input  wire logic        has_parent,
    input  wire logic        wait_flag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      result_id,
    output logic [4:0]       killed_count
);
    rrtt_pkg::cmd_t  cmd;
    rrtt_pkg::stat_t stat;

    rrtt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    rrtt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .func(func), .task_id(task_id), .parent_id(parent_id),
        .has_parent(has_parent), .wait_flag(wait_flag),
        .status(status), .result_id(result_id), .killed_count(killed_count)
    );

    assign out_valid = stat.out_full;
endmodule
`default_nettype wire
